// ===== hdl/pole_pkg.sv =====
`timescale 1ns / 1ps
package pole_pkg;

  typedef enum logic [3:0] {
    FN_CLEAR     = 4'd0,
    FN_READOUT   = 4'd1,
    FN_COUNT     = 4'd2,
    FN_SEARCH    = 4'd3,
    FN_INS_FRONT = 4'd4,
    FN_INS_AT    = 4'd5,
    FN_INS_BACK  = 4'd6,
    FN_DEL_FRONT = 4'd7,
    FN_DEL_AT    = 4'd8,
    FN_DEL_BACK  = 4'd9
  } func_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // Datapath actions requested by the controller.
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_LOAD    = 3'd1,
    ACT_STEP    = 3'd2,
    ACT_WRITE   = 3'd3,
    ACT_SET_CNT = 3'd4
  } act_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    act_t        act;
    logic        rd_en;
    logic [6:0]  rd_addr;
    logic        wr_en;
    logic [6:0]  wr_addr;
    logic        wr_sel_val;
    logic [6:0]  cnt_val;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [6:0]  count;
    logic        match;
  } dp_stat_t;

endpackage

// ===== hdl/pole_if.sv =====
`timescale 1ns / 1ps
interface pole_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         func;
  logic signed [31:0] value;
  logic [6:0]         position;
  modport source (output valid, func, value, position, input ready);
  modport sink   (input valid, func, value, position, output ready);
endinterface

interface pole_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               found;
  logic signed [31:0] element;
  logic [6:0]         length;
  logic               last;
  modport source (output valid, status, found, element, length, last, input ready);
  modport sink   (input valid, status, found, element, length, last, output ready);
endinterface

// ===== hdl/positional_ordered_list_engine.sv =====
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY signed 32-bit values held in one memory, with
// a controller that walks it entry by entry. Clear, count, delete from back and
// every refused operation need no walk; an insert or delete moves each shifted
// entry with one read and one write on the single memory port. A search reads
// entries in order until a match or the last entry, and a readout gives one
// beat per entry; a stalled result beat adds its wait. One item is in work at a
// time; the element store needs no clearing after reset.
module positional_ordered_list_engine
  import pole_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  pole_in_if.sink    in_ch,
  pole_out_if.source out_ch
);

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [31:0] rd_data;

  pole_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .rd_data (rd_data),
    .stat    (stat),
    .cmd     (cmd)
  );

  pole_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .value   (in_ch.value),
    .rd_data (rd_data),
    .stat    (stat)
  );

endmodule

// ===== hdl/pole_datapath.sv =====
`timescale 1ns / 1ps
module pole_datapath
  import pole_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  input  logic signed [31:0] value,
  output logic [31:0]        rd_data,
  output dp_stat_t           stat
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [31:0] mem [CAPACITY];
  logic [31:0] rd_data_r;
  logic [6:0]  count_r;
  logic [31:0] key_r;

  // Single-port style memory: one write and one registered read per cycle.
  // The new element comes from the value latched when the beat was taken.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_sel_val ? key_r : rd_data_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr[AW-1:0]];
    end
  end

  // Element count and the latched search key.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.act == ACT_SET_CNT) begin
      count_r <= cmd.cnt_val;
    end
    if (cmd.act == ACT_LOAD) begin
      key_r <= value;
    end
  end

  assign rd_data    = rd_data_r;
  assign stat.count = count_r;
  assign stat.match = (rd_data_r == key_r);

endmodule

// ===== hdl/pole_ctrl.sv =====
`timescale 1ns / 1ps
module pole_ctrl
  import pole_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  pole_in_if.sink     in_ch,
  pole_out_if.source  out_ch,
  input  logic [31:0] rd_data,
  input  dp_stat_t    stat,
  output dp_cmd_t     cmd
);

  localparam logic [6:0] CAP = 7'(CAPACITY);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SHIFT = 7'b0000010,
    S_SWR   = 7'b0000100,
    S_RDREQ = 7'b0001000,
    S_RDOUT = 7'b0010000,
    S_SRCH  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [6:0]  idx_r, idx_nxt;     // walking index
  logic [6:0]  end_r, end_nxt;     // walk bound
  logic        dir_r, dir_nxt;     // 1: shift up (insert), 0: shift down (delete)
  logic [6:0]  newcnt_r, newcnt_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [1:0]  ost_r, ost_nxt;
  logic        ofnd_r, ofnd_nxt;
  logic [31:0] oel_r, oel_nxt;
  logic        olast_r, olast_nxt;
  logic        busy_in;

  assign out_ch.valid   = ovalid_r;
  assign out_ch.status  = ost_r;
  assign out_ch.found   = ofnd_r;
  assign out_ch.element = oel_r;
  assign out_ch.length  = stat.count;
  assign out_ch.last    = olast_r;

  // New items are taken only in idle with the result register free.
  assign busy_in     = (state_r != S_IDLE) || (ovalid_r && !out_ch.ready);
  assign in_ch.ready = !busy_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
    idx_r    <= idx_nxt;
    end_r    <= end_nxt;
    dir_r    <= dir_nxt;
    newcnt_r <= newcnt_nxt;
    ost_r    <= ost_nxt;
    ofnd_r   <= ofnd_nxt;
    oel_r    <= oel_nxt;
    olast_r  <= olast_nxt;
  end

  always_comb begin
    logic [6:0] cnt;
    logic [6:0] pos;
    logic       ofree;
    cnt        = stat.count;
    pos        = in_ch.position;
    ofree      = !ovalid_r || out_ch.ready;
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    end_nxt    = end_r;
    dir_nxt    = dir_r;
    newcnt_nxt = newcnt_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    ost_nxt    = ost_r;
    ofnd_nxt   = ofnd_r;
    oel_nxt    = oel_r;
    olast_nxt  = olast_r;
    cmd            = '0;
    cmd.act        = ACT_NONE;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid && !busy_in) begin
          ost_nxt   = ST_OK;
          ofnd_nxt  = 1'b0;
          oel_nxt   = '0;
          olast_nxt = 1'b1;
          state_nxt = S_RESP;
          cmd.act   = ACT_LOAD;
          case (in_ch.func)
            FN_CLEAR: begin
              cmd.act = ACT_SET_CNT;
              cmd.cnt_val = '0;
            end
            FN_READOUT: begin
              if (cnt == 0) ost_nxt = ST_EMPTY;
              else begin
                idx_nxt = '0;
                state_nxt = S_RDREQ;
              end
            end
            FN_SEARCH: begin
              if (cnt == 0) ost_nxt = ST_EMPTY;
              else begin
                idx_nxt = '0;
                cmd.rd_en = 1'b1;
                cmd.rd_addr = '0;
                state_nxt = S_SRCH;
              end
            end
            FN_INS_FRONT, FN_INS_AT, FN_INS_BACK: begin
              if (in_ch.func == FN_INS_AT && cnt == 0) ost_nxt = ST_EMPTY;
              else if (in_ch.func == FN_INS_AT && (pos == 0 || pos > cnt + 7'd1))
                ost_nxt = ST_BADPOS;
              else if (cnt >= CAP) ost_nxt = ST_FULL;
              else begin
                dir_nxt = 1'b1;
                idx_nxt = cnt;
                newcnt_nxt = cnt + 7'd1;
                end_nxt = (in_ch.func == FN_INS_FRONT) ? 7'd0 :
                          (in_ch.func == FN_INS_BACK)  ? cnt  : pos - 7'd1;
                state_nxt = S_SHIFT;
              end
            end
            FN_DEL_FRONT, FN_DEL_AT: begin
              if (cnt == 0) ost_nxt = ST_EMPTY;
              else if (in_ch.func == FN_DEL_AT && (pos == 0 || pos > cnt))
                ost_nxt = ST_BADPOS;
              else begin
                dir_nxt = 1'b0;
                idx_nxt = (in_ch.func == FN_DEL_FRONT) ? 7'd0 : pos - 7'd1;
                end_nxt = cnt - 7'd1;
                newcnt_nxt = cnt - 7'd1;
                state_nxt = S_SHIFT;
              end
            end
            FN_DEL_BACK: begin
              if (cnt == 0) ost_nxt = ST_EMPTY;
              else begin
                cmd.act = ACT_SET_CNT;
                cmd.cnt_val = cnt - 7'd1;
              end
            end
            default: ;
          endcase
        end
      end
      // Insert: read entry idx-1 then write it at idx, down to end.
      // Delete: read entry idx+1 then write it at idx, up to end.
      S_SHIFT: begin
        if (idx_r == end_r) begin
          if (dir_r) begin
            cmd.wr_en = 1'b1;
            cmd.wr_addr = idx_r;
            cmd.wr_sel_val = 1'b1;
          end
          cmd.act = ACT_SET_CNT;
          cmd.cnt_val = newcnt_r;
          state_nxt = S_RESP;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_addr = dir_r ? idx_r - 7'd1 : idx_r + 7'd1;
          state_nxt = S_SWR;
        end
      end
      S_SWR: begin
        cmd.wr_en = 1'b1;
        cmd.wr_addr = idx_r;
        idx_nxt = dir_r ? idx_r - 7'd1 : idx_r + 7'd1;
        state_nxt = S_SHIFT;
      end
      S_RDREQ: begin
        if (ofree) begin
          cmd.rd_en = 1'b1;
          cmd.rd_addr = idx_r;
          state_nxt = S_RDOUT;
        end
      end
      S_RDOUT: begin
        ovalid_nxt = 1'b1;
        ost_nxt = ST_OK;
        oel_nxt = rd_data;
        olast_nxt = (idx_r + 7'd1 == cnt);
        idx_nxt = idx_r + 7'd1;
        state_nxt = (idx_r + 7'd1 == cnt) ? S_IDLE : S_RDREQ;
      end
      S_SRCH: begin
        if (stat.match) begin
          ofnd_nxt = 1'b1;
          state_nxt = S_RESP;
        end else if (idx_r + 7'd1 == cnt) begin
          state_nxt = S_RESP;
        end else begin
          idx_nxt = idx_r + 7'd1;
          cmd.rd_en = 1'b1;
          cmd.rd_addr = idx_r + 7'd1;
        end
      end
      S_RESP: begin
        if (ofree) begin
          ovalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import pole_pkg::*;

  localparam int CAP = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pole_in_if  in_ch();
  pole_out_if out_ch();

  positional_ordered_list_engine #(.CAPACITY(CAP)) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  typedef struct {
    logic [1:0]         status;
    logic               found;
    logic signed [31:0] element;
    logic [6:0]         length;
    logic               last;
  } beat_t;

  // A directed row: operation, plus an optional typed-in result for the final beat.
  typedef struct {
    logic [3:0]         func;
    logic signed [31:0] value;
    logic [6:0]         position;
    bit                 typed;
    logic [1:0]         t_status;
    logic [6:0]         t_length;
  } row_t;

  // Mirror of the list contents.
  logic signed [31:0] list_q[$];
  beat_t              pending_beats[$];
  int                 errors = 0;
  int                 beats_seen = 0;
  int                 items_sent = 0;
  int                 full_hits = 0;
  int                 rx_phase = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model one operation and queue the beats it should produce.
  function automatic void predict_list_op(logic [3:0] fn, logic signed [31:0] v,
                                          logic [6:0] p);
    beat_t b;
    int n;
    n = list_q.size();
    b.status = ST_OK;
    b.found = 1'b0;
    b.element = '0;
    b.last = 1'b1;
    case (fn)
      FN_CLEAR: list_q.delete();
      FN_READOUT: begin
        if (n == 0) begin
          b.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < n; i++) begin
            b.element = list_q[i];
            b.length = 7'(n);
            b.last = (i == n - 1);
            pending_beats.push_back(b);
          end
          return;
        end
      end
      FN_COUNT: ;
      FN_SEARCH: begin
        if (n == 0) b.status = ST_EMPTY;
        else foreach (list_q[i]) if (list_q[i] == v) b.found = 1'b1;
      end
      FN_INS_FRONT: begin
        if (n >= CAP) b.status = ST_FULL;
        else list_q.push_front(v);
      end
      FN_INS_AT: begin
        if (n == 0) b.status = ST_EMPTY;
        else if (p == 0 || p > n + 1) b.status = ST_BADPOS;
        else if (n >= CAP) b.status = ST_FULL;
        else list_q.insert(p - 1, v);
      end
      FN_INS_BACK: begin
        if (n >= CAP) b.status = ST_FULL;
        else list_q.push_back(v);
      end
      FN_DEL_FRONT: begin
        if (n == 0) b.status = ST_EMPTY;
        else void'(list_q.pop_front());
      end
      FN_DEL_AT: begin
        if (n == 0) b.status = ST_EMPTY;
        else if (p == 0 || p > n) b.status = ST_BADPOS;
        else list_q.delete(p - 1);
      end
      FN_DEL_BACK: begin
        if (n == 0) b.status = ST_EMPTY;
        else void'(list_q.pop_back());
      end
      default: ;
    endcase
    if (b.status == ST_FULL) full_hits++;
    b.length = 7'(list_q.size());
    pending_beats.push_back(b);
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = '0;
    in_ch.value = '0;
    in_ch.position = '0;
    out_ch.ready = 1'b0;
  end

  // Send one item, holding it until the block takes it.
  task automatic send_item(logic [3:0] fn, logic signed [31:0] v, logic [6:0] p);
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.value <= v;
    in_ch.position <= p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_list_op(fn, v, p);
    items_sent++;
  endtask

  // Burst sender: may drop valid for a random gap between bursts.
  int burst_left = 0;
  task automatic send_paced(logic [3:0] fn, logic signed [31:0] v, logic [6:0] p);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    send_item(fn, v, p);
  endtask

  // Receiver stall pattern: alternating phases of always-ready, sparse and random.
  always @(posedge clk) begin
    int cyc;
    cyc = rx_phase % 300;
    rx_phase <= rx_phase + 1;
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (cyc < 100) out_ch.ready <= 1'b1;
    else if (cyc < 200) out_ch.ready <= (cyc % 4 == 0);
    else out_ch.ready <= ($urandom_range(0, 2) != 0);
  end

  // Compare each beat with the oldest expectation.
  always @(posedge clk) begin
    beat_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beats_seen++;
      if (pending_beats.size() == 0) begin
        $error("Result beat with nothing expected");
        errors++;
      end else begin
        e = pending_beats.pop_front();
        if (out_ch.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_ch.status);
          errors++;
        end
        if (out_ch.found !== e.found) begin
          $error("found: expected %0d, got %0d", e.found, out_ch.found);
          errors++;
        end
        if (out_ch.element !== e.element) begin
          $error("element: expected %0d, got %0d", e.element, out_ch.element);
          errors++;
        end
        if (out_ch.length !== e.length) begin
          $error("length: expected %0d, got %0d", e.length, out_ch.length);
          errors++;
        end
        if (out_ch.last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_ch.last);
          errors++;
        end
      end
    end
  end

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  row_t dir_rows[$];

  function automatic void add_row(logic [3:0] fn, logic signed [31:0] v, logic [6:0] p,
                                  bit typed = 0, logic [1:0] st = 0, logic [6:0] ln = 0);
    row_t r;
    r.func = fn; r.value = v; r.position = p;
    r.typed = typed; r.t_status = st; r.t_length = ln;
    dir_rows.push_back(r);
  endfunction

  // Main stimulus.
  initial begin
    logic [3:0] fn;
    logic [6:0] p;
    int n;
    int k;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-list cases, extremes, bad positions, every operation.
    add_row(FN_READOUT,   0, 0, 1, ST_EMPTY, 0);
    add_row(FN_SEARCH,    5, 0, 1, ST_EMPTY, 0);
    add_row(FN_DEL_FRONT, 0, 0, 1, ST_EMPTY, 0);
    add_row(FN_DEL_AT,    0, 1, 1, ST_EMPTY, 0);
    add_row(FN_DEL_BACK,  0, 0, 1, ST_EMPTY, 0);
    add_row(FN_INS_AT,    3, 1, 1, ST_EMPTY, 0);
    add_row(FN_INS_BACK,  32'sh7FFF_FFFF, 0, 1, ST_OK, 1);
    add_row(FN_INS_FRONT, 32'sh8000_0000, 0, 1, ST_OK, 2);
    add_row(FN_INS_AT,    7, 0, 1, ST_BADPOS, 2);
    add_row(FN_INS_AT,    7, 4, 1, ST_BADPOS, 2);
    add_row(FN_INS_AT,    7, 3, 1, ST_OK, 3);
    add_row(FN_INS_AT,    9, 1, 1, ST_OK, 4);
    add_row(FN_INS_AT,    -1, 7'h7F, 1, ST_BADPOS, 4);
    add_row(FN_SEARCH,    32'sh8000_0000, 0);
    add_row(FN_SEARCH,    12345, 0);
    add_row(FN_READOUT,   0, 0);
    add_row(FN_DEL_AT,    0, 0, 1, ST_BADPOS, 4);
    add_row(FN_DEL_AT,    0, 5, 1, ST_BADPOS, 4);
    add_row(FN_DEL_AT,    0, 2, 1, ST_OK, 3);
    add_row(FN_COUNT,     0, 0, 1, ST_OK, 3);
    add_row(4'd10,        0, 0, 1, ST_OK, 3);
    add_row(4'd15,        -1, 7'h7F, 1, ST_OK, 3);
    add_row(FN_DEL_FRONT, 0, 0, 1, ST_OK, 2);
    add_row(FN_DEL_BACK,  0, 0, 1, ST_OK, 1);
    add_row(FN_CLEAR,     0, 0, 1, ST_OK, 0);

    foreach (dir_rows[i]) begin
      send_paced(dir_rows[i].func, dir_rows[i].value, dir_rows[i].position);
      if (dir_rows[i].typed &&
          (pending_beats[$].status !== dir_rows[i].t_status ||
           pending_beats[$].length !== dir_rows[i].t_length)) begin
        $error("directed row %0d: predictor disagrees with table", i);
        errors++;
      end
    end

    // Fill to capacity, hit the full cases, then drain.
    for (int i = 0; i < CAP; i++) send_paced(FN_INS_BACK, rand_value(), 0);
    send_paced(FN_INS_FRONT, 1, 0);
    send_paced(FN_INS_BACK, 1, 0);
    send_paced(FN_INS_AT, 1, 7'd64);
    send_paced(FN_INS_AT, 1, 7'd66);
    send_paced(FN_READOUT, 0, 0);
    send_paced(FN_DEL_AT, 0, 7'd64);
    send_paced(FN_DEL_AT, 0, 7'd1);
    send_paced(FN_CLEAR, 0, 0);

    // Random part: mostly valid operations on a small list, some noise.
    for (int i = 0; i < 260; i++) begin
      n = list_q.size();
      k = $urandom_range(0, 99);
      if (k < 2) fn = FN_CLEAR;
      else if (k < 6) fn = FN_READOUT;
      else if (k < 10) fn = FN_COUNT;
      else if (k < 20) fn = FN_SEARCH;
      else if (k < 3 + 55 && n < 20) fn = 4'($urandom_range(FN_INS_FRONT, FN_INS_BACK));
      else if (k < 90) fn = 4'($urandom_range(FN_DEL_FRONT, FN_DEL_BACK));
      else if (k < 94) fn = 4'($urandom_range(10, 15));
      else fn = 4'($urandom_range(FN_INS_FRONT, FN_INS_BACK));
      if ($urandom_range(0, 9) == 0) p = 7'($urandom);
      else p = 7'($urandom_range(0, n + 1));
      if (fn == FN_SEARCH && n > 0 && $urandom_range(0, 1))
        send_paced(fn, list_q[$urandom_range(0, n - 1)], p);
      else
        send_paced(fn, rand_value(), p);
    end
    in_ch.valid <= 1'b0;

    while (pending_beats.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Sent %0d items, checked %0d result beats, %0d full-list refusals.",
             items_sent, beats_seen, full_hits);
    if (errors == 0 && pending_beats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
